@@ rtl/core/cofne_pkg.sv @@
package cofne_pkg;

  // CORDIC depth, limited to the 32 entries of the arctangent table
  localparam int CordicStages = 16;
  localparam int NumStages    = (CordicStages > 32) ? 32 : CordicStages;

  // Stage index, wide enough for the largest table
  localparam int StageW = 5;
  // CORDIC x/y datapath: body x stays below 2^34, gain below 1.65
  localparam int DataW  = 38;
  // Angle accumulator: 32-bit binary angle plus one bit of headroom
  localparam int ZW     = 33;
  localparam int AngW   = 32;
  localparam int PosW   = 32;
  localparam int DistW  = 31;
  localparam int PitchW = 18;
  localparam int YawW   = 16;

  // Configuration register indexes
  localparam logic [1:0] CfgMount = 2'd0;
  localparam logic [1:0] CfgPCos  = 2'd1;
  localparam logic [1:0] CfgPSin  = 2'd2;

  localparam logic [PosW-1:0]   MountRst = 32'd1311;
  localparam logic [PitchW-1:0] PCosRst  = 18'd46341;
  localparam logic [PitchW-1:0] PSinRst  = 18'd46341;

  // atan(2^-i) in units of pi/2^31
  localparam logic [AngW-1:0] AtanTab [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Integer square root, one result bit per pass (elaboration only)
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] bit_w;
    r   = 64'd0;
    rem = v;
    for (int k = 31; k >= 0; k--) begin
      bit_w = 64'd1 << (2 * k);
      if (rem >= r + bit_w) begin
        rem = rem - (r + bit_w);
        r   = (r >> 1) + bit_w;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // CORDIC gain over n stages, Q30, each product rounded half up
  function automatic logic [63:0] cordic_gain(int n);
    logic [63:0] g;
    logic [63:0] s;
    g = 64'd1 << 30;
    for (int i = 0; i < 32; i++) begin
      if (i < n && 2 * i <= 60) begin
        s = isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
        g = (g * s + (64'd1 << 29)) >> 30;
      end
    end
    return g;
  endfunction

  localparam logic [63:0] GainQ30    = cordic_gain(NumStages);
  localparam logic [63:0] GainInvQ30 = ((64'd1 << 60) + GainQ30 / 2) / GainQ30;
  localparam logic signed [30:0] GainK = signed'(31'(GainInvQ30));

  // Scaler input limit, +-2^33
  localparam int ClampW = 35;
  localparam logic signed [DataW-1:0] ScaleLim = signed'(DataW'(1) << 33);

  typedef struct packed {
    logic signed [PosW-1:0]   mount;
    logic signed [PitchW-1:0] pcos;
    logic signed [PitchW-1:0] psin;
  } cfg_t;

  // Vectoring pair (vx, vy) and rotation triple (rx, ry, z)
  typedef struct packed {
    logic signed [DataW-1:0] vx;
    logic signed [DataW-1:0] vy;
    logic signed [DataW-1:0] rx;
    logic signed [DataW-1:0] ry;
    logic signed [ZW-1:0]    z;
  } cord_t;

  typedef struct packed {
    logic signed [PosW-1:0] north;
    logic signed [PosW-1:0] east;
    logic [DistW-1:0]       ground;
  } res_t;

endpackage

@@ rtl/core/camera_offset_to_north_east_top.sv @@
// Camera offset to north/east converter.
// Input channel: in_valid_i / in_stall_o carry one item, a camera-frame target
// offset (right, down, forward, Q16.16 m) and a heading (binary angle, 32768 =
// pi). Output channel: out_valid_o / out_stall_i return one item per input:
// north and east offset (Q16.16 m, saturated) and horizontal distance.
// An item moves on a rising edge where valid is high and stall is low.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 mount
// offset, 1 pitch cosine, 2 pitch sine); other indexes are ignored. Write only
// while no item is in flight.
// Pipeline from accept to out_valid_o: three body-frame stages, one CORDIC
// cell per stage, three gain stages and the output register. Throughput: one
// item per cycle while no stall freezes the pipeline, set by the cell chain in
// which every cell holds one item and hands it on when the pipeline advances.
// Stall: the output register holds its item; one more item lands in a skid
// register, after which the whole pipeline freezes and in_stall_o rises.
// Reset: empties the pipeline and loads the default mount offset and pitch.
module camera_offset_to_north_east_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [31:0]                 cam_right_i,
  input  logic signed [31:0]                 cam_down_i,
  input  logic signed [31:0]                 cam_forward_i,
  input  logic signed [15:0]                 yaw_angle_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [31:0]                 north_offset_o,
  output logic signed [31:0]                 east_offset_o,
  output logic [30:0]                        ground_distance_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [31:0]                        cfg_wdata_i
);
  import cofne_pkg::*;

  // Configuration registers
  logic [PosW-1:0]   mount_q;
  logic [PitchW-1:0] pcos_q, psin_q;
  cfg_t              cfg;

  // Pipeline advances whenever the skid register is free
  logic adv;

  logic  front_v;
  cord_t front_d;

  logic  cell_v [NumStages+1];
  cord_t cell_d [NumStages+1];

  logic [2:0] sv_q;
  logic signed [PosW-1:0] north_w, east_w, dist_w;
  res_t res_w;

  res_t out_d, out_q, skid_d, skid_q;
  logic out_v_d, out_v_q, skid_v_d, skid_v_q, take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mount_q <= MountRst;
      pcos_q  <= PCosRst;
      psin_q  <= PSinRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMount: mount_q <= cfg_wdata_i;
        CfgPCos:  pcos_q  <= cfg_wdata_i[PitchW-1:0];
        CfgPSin:  psin_q  <= cfg_wdata_i[PitchW-1:0];
        default:  ;
      endcase
    end
  end

  assign cfg.mount = signed'(mount_q);
  assign cfg.pcos  = signed'(pcos_q);
  assign cfg.psin  = signed'(psin_q);

  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  cofne_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .right_i (cam_right_i),
    .down_i  (cam_down_i),
    .fwd_i   (cam_forward_i),
    .yaw_i   (yaw_angle_i),
    .cfg_i   (cfg),
    .valid_o (front_v),
    .data_o  (front_d)
  );

  assign cell_v[0] = front_v;
  assign cell_d[0] = front_d;

  // One CORDIC iteration per cell, both passes side by side
  for (genvar g = 0; g < NumStages; g++) begin : g_cell
    cofne_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .stage_i (StageW'(g)),
      .atan_i  (AtanTab[g]),
      .valid_i (cell_v[g]),
      .data_i  (cell_d[g]),
      .valid_o (cell_v[g+1]),
      .data_o  (cell_d[g+1])
    );
  end

  // Gain correction: three stages per value
  cofne_scale u_scale_n (
    .clk_i (clk_i),
    .en_i  (adv),
    .v_i   (cell_d[NumStages].rx),
    .res_o (north_w)
  );

  cofne_scale u_scale_e (
    .clk_i (clk_i),
    .en_i  (adv),
    .v_i   (cell_d[NumStages].ry),
    .res_o (east_w)
  );

  cofne_scale u_scale_d (
    .clk_i (clk_i),
    .en_i  (adv),
    .v_i   (cell_d[NumStages].vx),
    .res_o (dist_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (adv) begin
      sv_q <= {sv_q[1:0], cell_v[NumStages]};
    end
  end

  // Drop negative distances to zero; the scaler already caps the top
  assign res_w.north  = north_w;
  assign res_w.east   = east_w;
  assign res_w.ground = dist_w[PosW-1] ? '0 : dist_w[DistW-1:0];

  assign take = out_v_q && !out_stall_i;

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    priority if (skid_v_q) begin
      // Pipeline frozen: refill the output from the skid register
      if (take) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end
    end else if (sv_q[2]) begin
      if (!out_v_q || take) begin
        out_d   = res_w;
        out_v_d = 1'b1;
      end else begin
        // Output held: park the item
        skid_d   = res_w;
        skid_v_d = 1'b1;
      end
    end else if (take) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o       = out_v_q;
  assign north_offset_o    = out_q.north;
  assign east_offset_o     = out_q.east;
  assign ground_distance_o = out_q.ground;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds an item while the output is empty");

  a_skid_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid register filled without a stalled output");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !skid_v_q && !sv_q[2] |=> !out_v_q)
    else $error("output still valid after its item was taken");

endmodule

@@ rtl/core/cofne_front.sv @@
module cofne_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [31:0]      right_i,
  input  logic signed [31:0]      down_i,
  input  logic signed [31:0]      fwd_i,
  input  logic signed [15:0]      yaw_i,
  input  cofne_pkg::cfg_t         cfg_i,
  output logic                    valid_o,
  output cofne_pkg::cord_t        data_o
);
  import cofne_pkg::*;

  localparam logic signed [YawW-1:0] YawHi = 16'sd16383;
  localparam logic signed [YawW-1:0] YawLo = -16'sd16384;

  logic [2:0] v_q;

  logic signed [PitchW-1:0] pcos, psin;
  logic signed [PosW-1:0]   mount;

  // Stage 1: pitch products
  logic signed [49:0]     pc_d, pc_q, ps_d, ps_q;
  logic signed [PosW-1:0] by1_q;
  logic signed [YawW-1:0] yaw1_q;

  // Stage 2: body x
  logic signed [51:0]     sum_w;
  logic signed [35:0]     bx_d, bx_q;
  logic signed [PosW-1:0] by2_q;
  logic signed [YawW-1:0] yaw2_q;

  // Stage 3: quadrant fold and CORDIC start values
  logic                    neg;
  logic signed [YawW-1:0]  yawf;
  logic signed [DataW-1:0] bx_w, by_w;
  cord_t                   cord_d, cord_q;

  assign pcos  = cfg_i.pcos;
  assign psin  = cfg_i.psin;
  assign mount = cfg_i.mount;

  assign pc_d = pcos * fwd_i;
  assign ps_d = psin * down_i;

  // Round half up to Q16.16, then add the mount offset
  assign sum_w = 52'(pc_q) - 52'(ps_q) + 52'sd32768;
  assign bx_d  = 36'(sum_w >>> 16) + 36'(mount);

  always_comb begin
    bx_w = DataW'(bx_q);
    by_w = DataW'(by2_q);
    neg  = (yaw2_q > YawHi) || (yaw2_q < YawLo);
    // Flipping the top bit moves the heading by half a turn
    yawf = neg ? signed'(yaw2_q ^ 16'h8000) : yaw2_q;
    cord_d.vx = bx_q[35] ? -bx_w : bx_w;
    cord_d.vy = by_w;
    cord_d.rx = neg ? -bx_w : bx_w;
    cord_d.ry = neg ? -by_w : by_w;
    cord_d.z  = ZW'(signed'({yawf, 16'h0000}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q   <= pc_d;
      ps_q   <= ps_d;
      by1_q  <= right_i;
      yaw1_q <= yaw_i;
      bx_q   <= bx_d;
      by2_q  <= by1_q;
      yaw2_q <= yaw1_q;
      cord_q <= cord_d;
    end
  end

  assign valid_o = v_q[2];
  assign data_o  = cord_q;

endmodule

@@ rtl/core/cofne_cell.sv @@
module cofne_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [cofne_pkg::StageW-1:0] stage_i,
  input  logic [cofne_pkg::AngW-1:0]   atan_i,
  input  logic                         valid_i,
  input  cofne_pkg::cord_t             data_i,
  output logic                         valid_o,
  output cofne_pkg::cord_t             data_o
);
  import cofne_pkg::*;

  logic signed [DataW-1:0] vx, vy, rx, ry, vxs, vys, rxs, rys;
  logic signed [ZW-1:0]    z, at;
  logic                    valid_q;
  cord_t                   d_d, d_q;

  always_comb begin
    vx  = data_i.vx;
    vy  = data_i.vy;
    rx  = data_i.rx;
    ry  = data_i.ry;
    z   = data_i.z;
    at  = signed'(ZW'(atan_i));
    vxs = vx >>> stage_i;
    vys = vy >>> stage_i;
    rxs = rx >>> stage_i;
    rys = ry >>> stage_i;
    // Vectoring: drive y toward zero
    if (!vy[DataW-1]) begin
      d_d.vx = vx + vys;
      d_d.vy = vy - vxs;
    end else begin
      d_d.vx = vx - vys;
      d_d.vy = vy + vxs;
    end
    // Rotation: drive the angle toward zero
    if (!z[ZW-1]) begin
      d_d.rx = rx - rys;
      d_d.ry = ry + rxs;
      d_d.z  = z - at;
    end else begin
      d_d.rx = rx + rys;
      d_d.ry = ry - rxs;
      d_d.z  = z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = d_q;

  a_cell_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i |=> valid_o)
    else $error("cell dropped an item while advancing");

endmodule

@@ rtl/core/cofne_scale.sv @@
module cofne_scale (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [cofne_pkg::DataW-1:0] v_i,
  output logic signed [cofne_pkg::PosW-1:0]  res_o
);
  import cofne_pkg::*;

  logic signed [ClampW-1:0] c_d, c_q;
  logic signed [16:0]       vh;
  logic signed [18:0]       vl;
  logic signed [47:0]       ph_d, ph_q;
  logic signed [49:0]       pl_d, pl_q;
  logic signed [65:0]       sum_w;
  logic signed [35:0]       rnd;
  logic signed [PosW-1:0]   res_d, res_q;

  // Clamp to +-2^33
  always_comb begin
    priority if (v_i > ScaleLim) begin
      c_d = ClampW'(ScaleLim);
    end else if (v_i < -ScaleLim) begin
      c_d = ClampW'(-ScaleLim);
    end else begin
      c_d = ClampW'(v_i);
    end
  end

  // Split the gain product into two partial products
  assign vh   = c_q[34:18];
  assign vl   = signed'({1'b0, c_q[17:0]});
  assign ph_d = vh * GainK;
  assign pl_d = vl * GainK;

  // Recombine, round half up by 30 bits, saturate
  assign sum_w = (66'(ph_q) <<< 18) + 66'(pl_q) + (66'sd1 <<< 29);
  assign rnd   = 36'(sum_w >>> 30);

  always_comb begin
    priority if (rnd > 36'sh07FFFFFFF) begin
      res_d = 32'sh7FFFFFFF;
    end else if (rnd < -36'sh080000000) begin
      res_d = signed'(32'h80000000);
    end else begin
      res_d = rnd[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q   <= c_d;
      ph_q  <= ph_d;
      pl_q  <= pl_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ bench/tb_camera_offset_to_north_east_top.sv @@
module tb_camera_offset_to_north_east_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cofne_pkg::*;

  // Accept-to-result depth of the pipeline
  localparam int Latency   = NumStages + 7;
  // Cycles without any handshake before the run is declared hung
  localparam int IdleLimit = 4000;
  // Register index with no register behind it; writes to it must be dropped
  localparam logic [1:0] CfgNone = 2'd3;

  localparam logic signed [31:0] PosMax = 32'sh7FFFFFFF;
  localparam logic signed [31:0] PosMin = 32'sh80000000;
  localparam logic signed [31:0] Metre  = 32'sd65536;
  localparam logic signed [15:0] YawMax = 16'sh7FFF;
  localparam logic signed [15:0] YawMin = 16'sh8000;

  // Headings on either side of the +-90 degree fold, plus the ends of the range and zero
  localparam logic signed [15:0] YawEdges [7] = '{
    16'sd16383, 16'sd16384, -16'sd16384, -16'sd16385, 16'sh8000, 16'sh7FFF, 16'sd0
  };

  typedef struct packed {
    logic signed [31:0] right;
    logic signed [31:0] down;
    logic signed [31:0] fwd;
    logic signed [15:0] yaw;
  } pose_t;

  typedef enum int {StallNone, StallLight, StallHeavy, StallLong} stall_mode_e;

  // Holds the north/east/distance fixes predicted for accepted poses, oldest first
  class north_east_scoreboard;
    res_t   expected_fixes [$];
    int     errors;
    int     n_stages;
    longint gain_k;
    longint atan_units [32];

    function new();
      longint unsigned g;
      longint unsigned s;
      atan_units = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001, 64'h00000000
      };
      errors   = 0;
      n_stages = (CordicStages > 32) ? 32 : CordicStages;
      // Build the CORDIC gain in Q30, then its rounded inverse
      g = 64'd1 << 30;
      for (int i = 0; i < n_stages; i++) begin
        if (2 * i <= 60) begin
          s = int_root((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
          g = (g * s + (64'd1 << 29)) >> 30;
        end
      end
      gain_k = longint'(((64'd1 << 60) + g / 2) / g);
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      for (int k = 31; k >= 0; k--) begin
        b = r | (64'd1 << k);
        if (b * b <= v) r = b;
      end
      return r;
    endfunction

    function longint gain_scale(longint v);
      longint lim;
      lim = 64'sd8589934592;
      if (v > lim) v = lim;
      else if (v < -lim) v = -lim;
      return (v * gain_k + 64'sd536870912) >>> 30;
    endfunction

    function longint sat_pos(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function res_t predict_fix(pose_t p, cfg_t c);
      longint bx, by, x, y, z, xs, ys, yaw, d;
      res_t   r;
      bx = ((longint'($signed(c.pcos)) * longint'($signed(p.fwd))
            - longint'($signed(c.psin)) * longint'($signed(p.down))
            + 64'sd32768) >>> 16) + longint'($signed(c.mount));
      by = longint'($signed(p.right));

      // Vectoring on (|bx|, by): x converges to the scaled ground distance
      x = (bx < 0) ? -bx : bx;
      y = by;
      for (int i = 0; i < n_stages; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
        end else begin
          x = x - ys;
          y = y + xs;
        end
      end
      d = gain_scale(x);
      if (d < 0) d = 0;
      else if (d > 64'sd2147483647) d = 64'sd2147483647;

      // Fold headings past +-90 degrees by half a turn; -pi lands on zero
      x   = bx;
      y   = by;
      yaw = longint'($signed(p.yaw));
      if (yaw > 16383) begin
        yaw = yaw - 32768;
        x   = -x;
        y   = -y;
      end else if (yaw < -16384) begin
        yaw = yaw + 32768;
        x   = -x;
        y   = -y;
      end
      z = yaw * 65536;
      for (int i = 0; i < n_stages; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - atan_units[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + atan_units[i];
        end
      end
      x = sat_pos(gain_scale(x));
      y = sat_pos(gain_scale(y));

      r.north  = x[31:0];
      r.east   = y[31:0];
      r.ground = d[30:0];
      return r;
    endfunction

    function int pending();
      return expected_fixes.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_pose(pose_t p, cfg_t c);
      expected_fixes.push_back(predict_fix(p, c));
    endfunction

    task check_fix(res_t got);
      res_t want;
      if (expected_fixes.size() == 0) begin
        report($sformatf("result with nothing expected: north %0d east %0d dist %0d",
                         got.north, got.east, got.ground));
        return;
      end
      want = expected_fixes.pop_front();
      if (got.north !== want.north)
        report($sformatf("north got %0d want %0d", got.north, want.north));
      if (got.east !== want.east)
        report($sformatf("east got %0d want %0d", got.east, want.east));
      if (got.ground !== want.ground)
        report($sformatf("distance got %0d want %0d", got.ground, want.ground));
    endtask
  endclass

  // Every block input starts at a known value
  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic signed [31:0] cam_right   = '0;
  logic signed [31:0] cam_down    = '0;
  logic signed [31:0] cam_forward = '0;
  logic signed [15:0] yaw_angle   = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [31:0] north_offset;
  logic signed [31:0] east_offset;
  logic [30:0]        ground_distance;
  logic               cfg_we      = 1'b0;
  logic [1:0]         cfg_idx     = '0;
  logic [31:0]        cfg_wdata   = '0;

  // Copy of the register file as the block should hold it; starts at the reset values
  cfg_t cfg_mirror = '{mount: 32'sd1311, pcos: 18'sd46341, psin: 18'sd46341};

  north_east_scoreboard fixes_sb;
  pose_t       pose_seen;
  res_t        fix_seen;
  int          idle_cycles = 0;
  stall_mode_e stall_mode  = StallNone;
  int          stall_left  = 0;

  camera_offset_to_north_east_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .cam_right_i       (cam_right),
    .cam_down_i        (cam_down),
    .cam_forward_i     (cam_forward),
    .yaw_angle_i       (yaw_angle),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .north_offset_o    (north_offset),
    .east_offset_o     (east_offset),
    .ground_distance_o (ground_distance),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Receiver back-pressure: hop between a few stall patterns, each for a random stretch,
  // so that free-running spells, sparse stalls, dense stalls and long holds all occur
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(8, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= ((stall_left % 20) < 9);
    endcase
  end

  // Watch both channels on the edge itself: predict each accepted pose, check each
  // accepted fix, and trip the watchdog if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pose_seen = '{cam_right, cam_down, cam_forward, yaw_angle};
        fixes_sb.note_pose(pose_seen, cfg_mirror);
      end
      if (out_valid && !out_stall) begin
        fix_seen = '{north_offset, east_offset, ground_distance};
        fixes_sb.check_fix(fix_seen);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offsets: often a few metres, with full-range words and the extremes mixed in
  function automatic logic signed [31:0] rand_metres();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return PosMax;
      2:       return PosMin;
      3:       return 32'sd0;
      4:       return int'($urandom_range(0, 1 << 26)) - (1 << 25);
      default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_yaw();
    if ($urandom_range(0, 5) != 0) return 16'($urandom());
    return YawEdges[$urandom_range(0, 6)];
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    p.right = rand_metres();
    p.down  = rand_metres();
    p.fwd   = rand_metres();
    p.yaw   = rand_yaw();
    return p;
  endfunction

  function automatic cfg_t random_setting();
    cfg_t c;
    int   v;
    c.mount = rand_metres();
    v       = int'($urandom_range(0, 131072)) - 65536;
    c.pcos  = v[17:0];
    v       = int'($urandom_range(0, 131072)) - 65536;
    c.psin  = v[17:0];
    return c;
  endfunction

  // Offer one item and hold it until the block takes it; leave valid high
  task automatic send_pose(pose_t p);
    in_valid    <= 1'b1;
    cam_right   <= p.right;
    cam_down    <= p.down;
    cam_forward <= p.fwd;
    yaw_angle   <= p.yaw;
    do @(posedge clk); while (in_stall);
  endtask

  // Write all three registers plus one to the empty index, with junk in unused bits,
  // and advance the mirror as each write lands
  task automatic apply_setting(cfg_t c);
    logic [31:0] junk;
    junk      = $urandom();
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgPCos;
    cfg_wdata <= {junk[31:18], c.pcos};
    @(posedge clk);
    cfg_mirror.pcos = c.pcos;
    junk      = $urandom();
    cfg_idx   <= CfgNone;
    cfg_wdata <= junk;
    @(posedge clk);
    cfg_idx   <= CfgMount;
    cfg_wdata <= c.mount;
    @(posedge clk);
    cfg_mirror.mount = c.mount;
    junk      = $urandom();
    cfg_idx   <= CfgPSin;
    cfg_wdata <= {junk[31:18], c.psin};
    @(posedge clk);
    cfg_mirror.psin = c.psin;
    cfg_we    <= 1'b0;
  endtask

  // Field extremes, headings either side of the fold, -pi, saturating sums and
  // alternating bit patterns, all in one unbroken burst
  task automatic run_directed();
    pose_t picks [18];
    picks[0]  = '{32'sd0, 32'sd0, 32'sd0, 16'sd0};
    picks[1]  = '{PosMax, 32'sd0, 32'sd0, 16'sd0};
    picks[2]  = '{PosMin, 32'sd0, 32'sd0, 16'sd0};
    picks[3]  = '{32'sd0, 32'sd0, PosMax, 16'sd16383};
    picks[4]  = '{32'sd0, 32'sd0, PosMin, 16'sd16384};
    picks[5]  = '{32'sd0, PosMax, 32'sd0, -16'sd16384};
    picks[6]  = '{32'sd0, PosMin, 32'sd0, -16'sd16385};
    picks[7]  = '{PosMax, PosMax, PosMax, YawMax};
    picks[8]  = '{PosMin, PosMin, PosMin, YawMin};
    picks[9]  = '{Metre, 32'sd0, Metre, YawMin};
    picks[10] = '{32'sd0, 32'sd0, -32'sd327680, 16'sd8192};
    picks[11] = '{-32'sd196608, Metre, 32'sd131072, -16'sd8192};
    picks[12] = '{PosMax, PosMin, PosMax, 16'sd4096};
    picks[13] = '{PosMin, PosMax, PosMin, YawMax};
    picks[14] = '{32'sd32768, -32'sd16384, 32'sd196608, 16'sd1};
    picks[15] = '{-Metre, Metre, -Metre, -16'sd1};
    picks[16] = '{32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F, 16'sh5555};
    picks[17] = '{32'shAAAAAAAA, 32'sh55555555, 32'shF0F0F0F0, 16'shAAAA};
    foreach (picks[k]) send_pose(picks[k]);
  endtask

  // Random poses in bursts of random length; drop valid for a random gap between
  // bursts, or run straight on into the next one
  task automatic run_random(int count);
    int burst;
    int gap;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 48);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_pose(random_pose());
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  // Let every outstanding fix arrive, then allow the pipeline depth to settle
  task automatic drain();
    @(posedge clk);
    while (fixes_sb.pending() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  initial begin
    fixes_sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings first, untouched by any write
    run_directed();
    run_random(150);
    drain();

    // Level camera, a pitch extreme, values beyond +-1.0, another pitch extreme, then random
    apply_setting('{mount: 32'sd0, pcos: 18'sd65536, psin: 18'sd0});
    run_random(200);
    drain();
    apply_setting('{mount: PosMax, pcos: -18'sd65536, psin: 18'sd65536});
    run_random(150);
    drain();
    apply_setting('{mount: PosMin, pcos: 18'sh1FFFF, psin: 18'sh20000});
    run_random(150);
    drain();
    apply_setting('{mount: 32'sd1311, pcos: 18'sd0, psin: -18'sd65536});
    run_random(150);
    drain();

    for (int k = 0; k < 4; k++) begin
      apply_setting(random_setting());
      run_random(150);
      drain();
    end

    if (fixes_sb.pending() != 0) fixes_sb.report("expected fixes left over at the end");
    if (fixes_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cofne_pkg.sv
rtl/core/cofne_front.sv
rtl/core/cofne_cell.sv
rtl/core/cofne_scale.sv
rtl/core/camera_offset_to_north_east_top.sv
bench/tb_camera_offset_to_north_east_top.sv
